// ----- hw/rtl/edc_pkg.sv -----
// ----------------------------------------------------------------------------
// edc_pkg: shared types and constants for the epoch to calendar date block
// Holds the request classes, the queue entry and result types, calendar
// constants and the leap year and month length helpers.
// ----------------------------------------------------------------------------
package edc_pkg;

    localparam int unsigned BASE_YEAR    = 1970;
    localparam int unsigned BASE_WEEKDAY = 4;

    localparam logic [31:0] LIMIT_RESERVED = 32'hFFFD_5D00;
    localparam logic [31:0] LIMIT_PREDAY   = 32'hFFFE_AE80;

    localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
    localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
    localparam logic [16:0] SEC_PER_MIN  = 17'd60;

    // Reciprocals for the constant divisions; each quotient is exact over the
    // operand range it is used on.
    //   seconds / 86400 = ((seconds >> 7) * RECIP_DAY)  >> 35
    //   seconds / 3600  = ((seconds >> 4) * RECIP_HOUR) >> 21
    //   seconds / 60    = ((seconds >> 2) * RECIP_MIN)  >> 14
    //   days / 7        = (days * RECIP_WEEK)           >> 19
    localparam logic [25:0] RECIP_DAY  = 26'd50903317;
    localparam logic [13:0] RECIP_HOUR = 14'd9321;
    localparam logic [10:0] RECIP_MIN  = 11'd1093;
    localparam logic [16:0] RECIP_WEEK = 17'd74899;

    // Year field at the epoch and the fixed fields of the day before it
    localparam logic [7:0] YEAR_AT_BASE   = 8'(BASE_YEAR - 1900);
    localparam logic [7:0] PREDAY_YEAR    = 8'd69;
    localparam logic [3:0] PREDAY_MONTH   = 4'd11;
    localparam logic [4:0] PREDAY_MDAY    = 5'd31;
    localparam logic [8:0] PREDAY_YDAY    = 9'd364;
    localparam logic [2:0] PREDAY_WEEKDAY = 3'((BASE_WEEKDAY + 6) % 7);
    localparam logic [3:0] WEEK_LEN       = 4'd7;

    // Leap exceptions as offsets from 1900
    localparam logic [7:0] YEAR_1900 = 8'd0;
    localparam logic [7:0] YEAR_2100 = 8'd200;

    localparam logic [3:0] MONTH_FEB = 4'd1;
    localparam logic [3:0] MONTH_CNT = 4'd12;

    // Request classes
    localparam logic [1:0] KIND_NORMAL = 2'd0;
    localparam logic [1:0] KIND_PREDAY = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] adj;
        logic [31:0] secs;
    } entry_t;

    typedef struct packed {
        logic        range_error;
        logic [5:0]  second_of_minute;
        logic [5:0]  minute_of_hour;
        logic [4:0]  hour_of_day;
        logic [2:0]  weekday;
        logic [7:0]  year_since_1900;
        logic [8:0]  day_of_year;
        logic [3:0]  month_index;
        logic [4:0]  day_of_month;
        logic [31:0] adjusted_epoch;
    } result_t;

    function automatic logic is_leap(input logic [7:0] ys);
        return (ys[1:0] == 2'd0) && (ys != YEAR_1900) && (ys != YEAR_2100);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon)
            4'd1:                 len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:              len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ----- hw/rtl/edc_if.sv -----
// ----------------------------------------------------------------------------
// edc_if: request and response channels
// Valid/ready channels carrying the request and the broken-down date.
// ----------------------------------------------------------------------------
interface edc_req_if;
    logic               valid;
    logic               ready;
    logic [31:0]        epoch_seconds;
    logic signed [17:0] offset_seconds;

    modport source (output valid, output epoch_seconds, output offset_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, input offset_seconds, output ready);
endinterface

interface edc_rsp_if;
    logic        valid;
    logic        ready;
    logic        range_error;
    logic [5:0]  second_of_minute;
    logic [5:0]  minute_of_hour;
    logic [4:0]  hour_of_day;
    logic [2:0]  weekday;
    logic [7:0]  year_since_1900;
    logic [8:0]  day_of_year;
    logic [3:0]  month_index;
    logic [4:0]  day_of_month;
    logic [31:0] adjusted_epoch;

    modport source (output valid, output range_error, output second_of_minute,
                    output minute_of_hour, output hour_of_day, output weekday,
                    output year_since_1900, output day_of_year, output month_index,
                    output day_of_month, output adjusted_epoch, input ready);
    modport sink   (input valid, input range_error, input second_of_minute,
                    input minute_of_hour, input hour_of_day, input weekday,
                    input year_since_1900, input day_of_year, input month_index,
                    input day_of_month, input adjusted_epoch, output ready);
endinterface

// ----- hw/rtl/edc_front.sv -----
// ----------------------------------------------------------------------------
// edc_front: request classifier
// Applies the offset and sorts each request into normal, pre-epoch day or
// range error before it enters the queue.
// ----------------------------------------------------------------------------
module edc_front (
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [31:0]          epoch_seconds,
    input  logic signed [17:0]   offset_seconds,
    output logic                 push_valid,
    input  logic                 push_ready,
    output edc_pkg::entry_t      push_data
);
    import edc_pkg::*;

    logic [31:0] off_ext;
    logic [31:0] adj;
    logic        preday;

    assign off_ext = {{14{offset_seconds[17]}}, offset_seconds};
    assign adj     = epoch_seconds - off_ext;
    assign preday  = (adj >= LIMIT_PREDAY);

    always_comb
    begin
        push_data.adj  = adj;
        push_data.secs = preday ? (adj - LIMIT_PREDAY) : adj;
        if (epoch_seconds >= LIMIT_RESERVED)
            push_data.kind = KIND_ERROR;
        else if (preday)
            push_data.kind = KIND_PREDAY;
        else
            push_data.kind = KIND_NORMAL;
    end

    assign push_valid = in_valid;
    assign in_ready   = push_ready;

endmodule

// ----- hw/rtl/edc_queue.sv -----
// ----------------------------------------------------------------------------
// edc_queue: two-entry queue
// Decouples the classifier from the date sequencer.
// ----------------------------------------------------------------------------
module edc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  edc_pkg::entry_t      push_data,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output edc_pkg::entry_t      pop_data
);
    import edc_pkg::*;

    entry_t     mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// ----- hw/rtl/edc_back.sv -----
// ----------------------------------------------------------------------------
// edc_back: date sequencer
// Splits the seconds by reciprocal multiplication over a sequence of states, walks
// years and months, and holds the finished date in an output register.
// ----------------------------------------------------------------------------
module edc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  edc_pkg::entry_t      pop_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output edc_pkg::result_t     out_data
);
    import edc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DAY   = 4'd1;
    localparam logic [3:0] S_SPLIT = 4'd2;
    localparam logic [3:0] S_HOUR  = 4'd3;
    localparam logic [3:0] S_SOH   = 4'd4;
    localparam logic [3:0] S_MIN   = 4'd5;
    localparam logic [3:0] S_SEC   = 4'd6;
    localparam logic [3:0] S_YEAR  = 4'd7;
    localparam logic [3:0] S_MONTH = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]  state_reg, state_next;
    logic [31:0] secs_reg, secs_next;
    logic [16:0] rem_reg, rem_next;
    logic [13:0] wq_reg, wq_next;
    logic [2:0]  wmod_reg, wmod_next;
    logic [1:0]  kind_reg, kind_next;
    logic [31:0] adj_reg, adj_next;
    logic [15:0] days_reg, days_next;
    logic [7:0]  ys_reg, ys_next;
    logic [8:0]  yday_reg, yday_next;
    logic [3:0]  mon_reg, mon_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  min_reg, min_next;
    logic [5:0]  sec_reg, sec_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;

    logic [50:0] day_prod;
    logic [31:0] day_base;
    logic [31:0] sod_full;
    logic [32:0] week_prod;
    logic [15:0] week_base;
    logic [15:0] wmod_full;
    logic [26:0] hour_prod;
    logic [16:0] hour_base;
    logic [16:0] soh_full;
    logic [20:0] min_prod;
    logic [16:0] min_base;
    logic [16:0] sec_full;
    logic        leap;
    logic [15:0] ylen;
    logic [15:0] mlen;
    logic [3:0]  wsum;
    logic [2:0]  wday_normal;
    logic        out_free;
    result_t     res;

    // Whole days, then seconds of the day and the week quotient
    assign day_prod  = 51'(secs_reg[31:7]) * 51'(RECIP_DAY);
    assign day_base  = 32'(days_reg) * 32'(SEC_PER_DAY);
    assign sod_full  = secs_reg - day_base;
    assign week_prod = 33'(days_reg) * 33'(RECIP_WEEK);

    // Day count modulo 7 from the registered week quotient
    assign week_base = 16'(wq_reg) * 16'(WEEK_LEN);
    assign wmod_full = days_reg - week_base;

    // Hours from seconds of the day, then minutes and seconds of the hour
    assign hour_prod = 27'(rem_reg[16:4]) * 27'(RECIP_HOUR);
    assign hour_base = 17'(hour_reg) * SEC_PER_HOUR;
    assign soh_full  = rem_reg - hour_base;
    assign min_prod  = 21'(rem_reg[11:2]) * 21'(RECIP_MIN);
    assign min_base  = 17'(min_reg) * SEC_PER_MIN;
    assign sec_full  = rem_reg - min_base;

    assign leap = is_leap(ys_reg);
    assign ylen = leap ? 16'd366 : 16'd365;
    assign mlen = {11'd0, month_len(mon_reg, leap && (mon_reg == MONTH_FEB))};

    assign wsum        = 4'(BASE_WEEKDAY) + {1'b0, wmod_reg};
    assign wday_normal = (wsum >= WEEK_LEN) ? 3'(wsum - WEEK_LEN) : wsum[2:0];

    assign out_free  = !out_valid_reg || out_ready;
    assign pop_ready = (state_reg == S_IDLE);

    always_comb
    begin
        res = '0;
        if (kind_reg == KIND_ERROR)
        begin
            res.range_error    = 1'b1;
            res.adjusted_epoch = '1;
        end
        else
        begin
            res.second_of_minute = sec_reg;
            res.minute_of_hour   = min_reg;
            res.hour_of_day      = hour_reg;
            res.adjusted_epoch   = adj_reg;
            if (kind_reg == KIND_PREDAY)
            begin
                res.weekday         = PREDAY_WEEKDAY;
                res.year_since_1900 = PREDAY_YEAR;
                res.day_of_year     = PREDAY_YDAY;
                res.month_index     = PREDAY_MONTH;
                res.day_of_month    = PREDAY_MDAY;
            end
            else
            begin
                res.weekday         = wday_normal;
                res.year_since_1900 = ys_reg;
                res.day_of_year     = yday_reg;
                res.month_index     = mon_reg;
                res.day_of_month    = days_reg[4:0] + 5'd1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        secs_next      = secs_reg;
        rem_next       = rem_reg;
        wq_next        = wq_reg;
        wmod_next      = wmod_reg;
        kind_next      = kind_reg;
        adj_next       = adj_reg;
        days_next      = days_reg;
        ys_next        = ys_reg;
        yday_next      = yday_reg;
        mon_next       = mon_reg;
        hour_next      = hour_reg;
        min_next       = min_reg;
        sec_next       = sec_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    kind_next  = pop_data.kind;
                    adj_next   = pop_data.adj;
                    secs_next  = pop_data.secs;
                    state_next = (pop_data.kind == KIND_ERROR) ? S_DONE : S_DAY;
                end
            end
            S_DAY:
            begin
                days_next  = day_prod[50:35];
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                rem_next   = sod_full[16:0];
                wq_next    = week_prod[32:19];
                state_next = S_HOUR;
            end
            S_HOUR:
            begin
                hour_next  = hour_prod[25:21];
                wmod_next  = wmod_full[2:0];
                state_next = S_SOH;
            end
            S_SOH:
            begin
                rem_next   = soh_full;
                state_next = S_MIN;
            end
            S_MIN:
            begin
                min_next   = min_prod[19:14];
                state_next = S_SEC;
            end
            S_SEC:
            begin
                sec_next   = sec_full[5:0];
                ys_next    = YEAR_AT_BASE;
                state_next = (kind_reg == KIND_PREDAY) ? S_DONE : S_YEAR;
            end
            S_YEAR:
            begin
                if (days_reg >= ylen)
                begin
                    days_next = days_reg - ylen;
                    ys_next   = ys_reg + 8'd1;
                end
                else
                begin
                    yday_next  = days_reg[8:0];
                    mon_next   = '0;
                    state_next = S_MONTH;
                end
            end
            S_MONTH:
            begin
                if (days_reg == 16'd0 || mon_reg >= MONTH_CNT || days_reg < mlen)
                    state_next = S_DONE;
                else
                begin
                    days_next = days_reg - mlen;
                    mon_next  = mon_reg + 4'd1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_next       = res;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        secs_reg  <= secs_next;
        rem_reg   <= rem_next;
        wq_reg    <= wq_next;
        wmod_reg  <= wmod_next;
        kind_reg  <= kind_next;
        adj_reg   <= adj_next;
        days_reg  <= days_next;
        ys_reg    <= ys_next;
        yday_reg  <= yday_next;
        mon_reg   <= mon_next;
        hour_reg  <= hour_next;
        min_reg   <= min_next;
        sec_reg   <= sec_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- hw/rtl/epoch_to_calendar_date.sv -----
// ----------------------------------------------------------------------------
// epoch_to_calendar_date: seconds since 1970 to broken-down UTC date
// Converts a 32-bit epoch and a local offset into time of day, weekday,
// year, day of year, month and day of month.
// ----------------------------------------------------------------------------
// Usage:
//   req carries epoch_seconds and a signed offset_seconds; a transfer happens
//   when valid and ready are both high. rsp returns one result per request,
//   in request order, under the same valid/ready rule.
//   The classifier applies the offset and flags range errors as the request
//   is taken; a two-entry queue holds classified requests so new transfers
//   can arrive while the sequencer is busy or a result waits on rsp.
//   From the req transfer to rsp valid with an idle sequencer, a range
//   error goes straight to the output register, the pre-epoch day runs the
//   time of day states S_DAY, S_SPLIT, S_HOUR, S_SOH, S_MIN and S_SEC, and a
//   normal date also walks the years from 1970 (up to 136) and the months
//   (up to 11). The time of day comes from reciprocal multiplication and
//   compare-free correction. The single sequencer takes a new item only
//   when idle, after the result of the last one is registered.
//   Reset clears the queue and the sequencer; no result is pending after it.
//   When the receiver stalls, the result holds on rsp, the sequencer waits
//   with its next result, and req stalls once the queue is full.
// ----------------------------------------------------------------------------
module epoch_to_calendar_date (
    input  logic        clk,
    input  logic        rst_n,
    edc_req_if.sink     req,
    edc_rsp_if.source   rsp
);
    import edc_pkg::*;

    entry_t  push_data;
    entry_t  pop_data;
    result_t out_data;
    logic    push_valid;
    logic    push_ready;
    logic    pop_valid;
    logic    pop_ready;

    // Classify and apply the offset on the way in
    edc_front u_front (
        .in_valid       (req.valid),
        .in_ready       (req.ready),
        .epoch_seconds  (req.epoch_seconds),
        .offset_seconds (req.offset_seconds),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_data      (push_data)
    );

    // Hold classified requests while the sequencer works
    edc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Split seconds, walk the calendar, and register the result
    edc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (out_data)
    );

    assign rsp.range_error      = out_data.range_error;
    assign rsp.second_of_minute = out_data.second_of_minute;
    assign rsp.minute_of_hour   = out_data.minute_of_hour;
    assign rsp.hour_of_day      = out_data.hour_of_day;
    assign rsp.weekday          = out_data.weekday;
    assign rsp.year_since_1900  = out_data.year_since_1900;
    assign rsp.day_of_year      = out_data.day_of_year;
    assign rsp.month_index      = out_data.month_index;
    assign rsp.day_of_month     = out_data.day_of_month;
    assign rsp.adjusted_epoch   = out_data.adjusted_epoch;

    // An error result carries an all-ones epoch and an empty date
    a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.range_error |->
            rsp.adjusted_epoch == 32'hFFFF_FFFF && rsp.day_of_month == 5'd0)
        else $error("error result with nonzero date fields");

    // A valid date has a real month and a one-based day
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.range_error |->
            rsp.month_index <= 4'd11 && rsp.day_of_month != 5'd0 && rsp.weekday <= 3'd6)
        else $error("calendar field out of range");

    // Time of day fields stay inside their ranges
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |->
            rsp.hour_of_day <= 5'd23 && rsp.minute_of_hour <= 6'd59 &&
            rsp.second_of_minute <= 6'd59)
        else $error("time of day field out of range");

endmodule
